[sv/rtcp_compound_packet_parser_defines.svh]
// Assertion macros used by the RTCP parser back end.
`ifndef RTCP_COMPOUND_PACKET_PARSER_DEFINES_SVH
`define RTCP_COMPOUND_PACKET_PARSER_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define RTCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the following cycle.
`define RTCP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/rtcp_pkg.sv]
// Types and constants shared by the RTCP compound packet parser.
package rtcp_pkg;

    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_TEXT    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [7:0] PT_SR   = 8'd200;
    localparam logic [7:0] PT_RR   = 8'd201;
    localparam logic [7:0] PT_SDES = 8'd202;
    localparam logic [7:0] PT_BYE  = 8'd203;
    localparam logic [7:0] PT_APP  = 8'd204;

    localparam logic [1:0] CFG_HIGH_ACC  = 2'd0;
    localparam logic [1:0] CFG_FIELD_EN  = 2'd1;
    localparam logic [1:0] CFG_PORT_THR  = 2'd2;

    localparam logic [4:0] FID_RR_SSRC = 5'd12;
    localparam logic [4:0] FID_CSRC    = 5'd19;
    localparam logic [4:0] FID_TEXT    = 5'd20;

    // SDES walk phases
    localparam logic [1:0] SD_CSRC = 2'd0;
    localparam logic [1:0] SD_TYPE = 2'd1;
    localparam logic [1:0] SD_LEN  = 2'd2;
    localparam logic [1:0] SD_DONE = 2'd3;

    localparam logic [17:0] NO_NEXT = 18'h3FFFF;
    localparam int          QDEPTH  = 4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [4:0]  field_id;
        logic [31:0] field_value;
        logic [15:0] text_offset;
        logic [7:0]  text_length;
        logic        is_match;
        logic        last_result;
    } t_out_item;

    // Classified work for the back end: optional field result plus optional verdict
    typedef struct packed {
        logic      has_field;
        t_out_item field;
        logic      has_verdict;
        logic      match;
    } t_work;

endpackage

[sv/rtcp_front.sv]
// Front end: walks the byte stream and classifies each byte into pending results.
module rtcp_front
    import rtcp_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    input  logic        i_high_accuracy,
    input  logic [22:0] i_field_enable_mask,
    input  logic [15:0] i_port_threshold,
    output logic        o_wvalid,
    input  logic        i_wready,
    output t_work       o_work
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [17:0] r_sp_start, n_sp_start, r_sp_end, n_sp_end;
    logic [17:0] r_item_next, n_item_next;
    logic [7:0]  r_ptype, n_ptype;
    logic [4:0]  r_rcount, n_rcount;
    logic [31:0] r_shift;
    logic [1:0]  r_phase, n_phase;
    logic        r_active, n_active, r_match, n_match, r_ports, n_ports;

    logic        acc;
    logic [31:0] shift_n;
    logic [17:0] p, start_eff, rel, e, nxt;
    logic [15:0] len;
    logic [15:0] k;
    logic        parse, emit_num, emit_txt;
    logic [4:0]  fid;

    assign o_ready  = i_wready;
    assign acc      = i_valid & o_ready;
    assign o_wvalid = i_valid;
    assign shift_n  = {r_shift[23:0], i_item.data_byte};
    assign p        = 18'(r_pos);

    function automatic logic en(input logic [22:0] m, input logic [4:0] id);
        logic r;
        r = m[id];
        if (id <= 5'd11) r = r | m[21];
        else if (id <= 5'd18) r = r | m[22];
        return r;
    endfunction

    // Per-byte parse step
    always_comb begin
        n_pos = r_pos; n_sp_start = r_sp_start; n_sp_end = r_sp_end;
        n_item_next = r_item_next; n_ptype = r_ptype; n_rcount = r_rcount;
        n_phase = r_phase; n_active = r_active; n_match = r_match; n_ports = r_ports;
        emit_num = 1'b0; emit_txt = 1'b0; fid = '0;
        len = shift_n[15:0];
        e = '0; nxt = '0;
        start_eff = (p == r_sp_end) ? p : r_sp_start;
        rel = p - start_eff;
        k = 16'(rel >> 2);
        if (r_pos == '0) begin
            n_ports = (i_item.source_port > i_port_threshold) &&
                      (i_item.destination_port > i_port_threshold);
        end
        parse = r_active && !(r_pos == '0 && !n_ports);
        if (r_pos == '0 && !n_ports) n_active = 1'b0;
        if (parse) begin
            n_sp_start = start_eff;
            if (rel == 18'd0) begin
                n_rcount = i_item.data_byte[4:0];
                n_phase  = SD_DONE;
                if (start_eff == '0 && i_item.data_byte[7:6] != 2'd2) begin
                    n_match = 1'b0; n_active = 1'b0;
                end
            end else if (rel == 18'd1) begin
                n_ptype = i_item.data_byte;
                if (i_item.data_byte < PT_SR || i_item.data_byte > PT_APP) begin
                    n_match = 1'b0; n_active = 1'b0;
                end else if (start_eff == '0 && !i_high_accuracy) begin
                    n_active = 1'b0;
                end
            end else if (rel == 18'd2) begin
                n_active = r_active;
            end else if (rel == 18'd3) begin
                e = start_eff + {len, 2'b00} + 18'd4;
                n_sp_end = (len == '0 || ({2'b0, start_eff} + {2'b0, len, 2'b00} + 20'd4)
                            > {2'b0, NO_NEXT}) ? NO_NEXT : e;
                if (r_ptype == PT_SDES && len >= 16'd2) n_phase = SD_CSRC;
            end else if (r_ptype == PT_SR) begin
                if (rel[1:0] == 2'b11 && (k <= 16'd6 || (r_rcount != '0 && k <= 16'd12))) begin
                    fid = 5'(k - 16'd1);
                    emit_num = en(i_field_enable_mask, fid);
                end
            end else if (r_ptype == PT_RR) begin
                if (rel[1:0] == 2'b11 && (k == 16'd1 || (r_rcount != '0 && k <= 16'd7))) begin
                    fid = 5'(k + 16'd11);
                    emit_num = en(i_field_enable_mask, fid);
                end
            end else if (r_ptype == PT_SDES) begin
                unique case (r_phase)
                    SD_CSRC: begin
                        if (rel == 18'd7) begin
                            fid = FID_CSRC;
                            emit_num = en(i_field_enable_mask, FID_CSRC);
                            n_phase = SD_TYPE;
                            n_item_next = start_eff + 18'd8;
                        end
                    end
                    SD_TYPE: begin
                        if (p == r_item_next)
                            n_phase = (i_item.data_byte == '0) ? SD_DONE : SD_LEN;
                    end
                    SD_LEN: begin
                        nxt = p + 18'd1 + 18'(i_item.data_byte);
                        if (nxt >= r_sp_end) begin
                            n_phase = SD_DONE;
                        end else begin
                            emit_txt = en(i_field_enable_mask, FID_TEXT);
                            n_item_next = nxt;
                            n_phase = SD_TYPE;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
        if (r_pos < POS_MAX) n_pos = r_pos + 1'b1;
        else n_active = 1'b0;
    end

    // Work item for the back end
    always_comb begin
        o_work = '0;
        o_work.has_field = emit_num | emit_txt;
        if (emit_txt) begin
            o_work.field.result_kind = KIND_TEXT;
            o_work.field.field_id    = FID_TEXT;
            o_work.field.text_offset = 16'(p + 18'd1);
            o_work.field.text_length = i_item.data_byte;
        end else begin
            o_work.field.result_kind = KIND_FIELD;
            o_work.field.field_id    = fid;
            o_work.field.field_value = shift_n;
        end
        o_work.has_verdict = i_item.last_byte;
        o_work.match = n_ports && (r_pos >= OFFSET_BITS'(3)) && n_match;
    end

    // State registers; cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_item.last_byte)) begin
            r_pos <= '0; r_sp_start <= '0; r_sp_end <= '0; r_item_next <= '0;
            r_ptype <= '0; r_rcount <= '0; r_shift <= '0; r_phase <= '0;
            r_active <= 1'b1; r_match <= 1'b1; r_ports <= 1'b0;
        end else if (acc) begin
            r_pos <= n_pos; r_sp_start <= n_sp_start; r_sp_end <= n_sp_end;
            r_item_next <= n_item_next; r_ptype <= n_ptype; r_rcount <= n_rcount;
            r_shift <= shift_n; r_phase <= n_phase; r_active <= n_active;
            r_match <= n_match; r_ports <= n_ports;
        end
    end

endmodule

[sv/rtcp_back.sv]
// Back end: queue of classified work, split into one result beat per cycle while the receiver is ready.
module rtcp_back
    import rtcp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wvalid,
    output logic      o_wready,
    input  t_work     i_work,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    `include "rtcp_compound_packet_parser_defines.svh"

    localparam int AW = $clog2(QDEPTH);

    t_work          r_q [QDEPTH];
    logic [AW-1:0]  r_rd, r_wr;
    logic [AW:0]    r_cnt;
    logic           r_half;
    logic           push, pop, head_two;
    t_work          head;

    assign head     = r_q[r_rd];
    assign o_wready = (r_cnt != (AW+1)'(QDEPTH));
    assign push     = i_wvalid && o_wready && (i_work.has_field || i_work.has_verdict);
    assign o_valid  = (r_cnt != '0);
    assign head_two = head.has_field && head.has_verdict;
    assign pop      = o_valid && i_ready && (!head_two || r_half);

    // Present field first, then verdict
    always_comb begin
        o_item = '0;
        if (head.has_field && !r_half) begin
            o_item = head.field;
        end else begin
            o_item.result_kind = KIND_VERDICT;
            o_item.is_match    = head.match;
            o_item.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0; r_half <= 1'b0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
            if (pop) r_half <= 1'b0;
            else if (o_valid && i_ready && head_two) r_half <= 1'b1;
        end
    end

    `RTCP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(QDEPTH), "queue overflow")
    `RTCP_ASSERT_IMP(a_half_two, i_clk, i_rst_n, r_half, head_two && o_valid, "split beat lost")
    `RTCP_ASSERT_NXT(a_empty_pop, i_clk, i_rst_n, !o_valid && !push, !o_valid, "phantom beat")

endmodule

[sv/rtcp_compound_packet_parser.sv]
// RTCP compound packet parser: top level with configuration registers.
// Accepts one payload byte per clock while the queue has room; each byte produces zero,
// one or two result beats (a field or text span, then the verdict on the last byte).
// Results pass through a four-entry queue drained at one beat per cycle while the
// receiver is ready; a byte that yields two results is split into two output beats.
module rtcp_compound_packet_parser
    import rtcp_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);

    logic        r_high_acc;
    logic [22:0] r_field_en;
    logic [15:0] r_port_thr;
    logic        wvalid, wready;
    t_work       work;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_acc <= 1'b1; r_field_en <= '0; r_port_thr <= 16'd1024;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIGH_ACC: r_high_acc <= i_cfg_data[0];
                CFG_FIELD_EN: r_field_en <= i_cfg_data;
                CFG_PORT_THR: r_port_thr <= i_cfg_data[15:0];
                default:      r_high_acc <= r_high_acc;
            endcase
        end
    end

    rtcp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(i_data),
        .i_high_accuracy(r_high_acc), .i_field_enable_mask(r_field_en),
        .i_port_threshold(r_port_thr),
        .o_wvalid(wvalid), .i_wready(wready), .o_work(work)
    );

    rtcp_back u_back (
        .i_clk, .i_rst_n, .i_wvalid(wvalid), .o_wready(wready), .i_work(work),
        .o_valid, .i_ready, .o_item(o_data)
    );

endmodule

[tb/rtcp_parse_checker.sv]
// Scoreboard for the RTCP parser: watches all channels, predicts results and compares them.
module rtcp_parse_checker
    import rtcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_data,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POS_LIMIT = 65535;

    // shadow of the configuration registers
    logic        hi_acc;
    logic [22:0] fld_mask;
    logic [15:0] port_thr;

    // per-packet parse state
    int unsigned byte_pos, sub_start, sub_end, item_next;
    logic [31:0] word_sr;
    logic [7:0]  pkt_type;
    logic [4:0]  rep_count;
    logic [1:0]  sdes_ph;
    logic        walking, still_ok, ports_good;

    t_out_item expected_results[$];
    int        err_count;

    assign o_errors  = err_count;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    function automatic void restart_packet();
        byte_pos = 0; sub_start = 0; sub_end = 0; item_next = 0;
        word_sr = '0; pkt_type = '0; rep_count = '0; sdes_ph = SD_CSRC;
        walking = 1'b1; still_ok = 1'b1; ports_good = 1'b0;
    endfunction

    function automatic bit field_on(input int unsigned id);
        if (fld_mask[id]) return 1'b1;
        if (id <= 11) return fld_mask[21];
        if (id <= 18) return fld_mask[22];
        return 1'b0;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input int unsigned id,
                                        input logic [31:0] val, input int unsigned off,
                                        input logic [7:0] len, input logic m,
                                        input logic lst);
        t_out_item r;
        r.result_kind = kind;
        r.field_id    = id[4:0];
        r.field_value = val;
        r.text_offset = off[15:0];
        r.text_length = len;
        r.is_match    = m;
        r.last_result = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void push_word(input int unsigned id);
        if (field_on(id)) push_result(KIND_FIELD, id, word_sr, 0, 8'd0, 1'b0, 1'b0);
    endfunction

    // one byte of the sub-packet walk
    function automatic void walk_byte(input int unsigned p, input logic [7:0] b);
        int unsigned rel, k, len, e, nxt;
        if (p == sub_end) sub_start = p;
        rel = p - sub_start;
        k = rel >> 2;
        case (rel)
            0: begin
                rep_count = b[4:0];
                sdes_ph = SD_DONE;
                if (sub_start == 0 && b[7:6] != 2'd2) begin
                    still_ok = 1'b0; walking = 1'b0;
                end
            end
            1: begin
                pkt_type = b;
                if (b < PT_SR || b > PT_APP) begin
                    still_ok = 1'b0; walking = 1'b0;
                end else if (sub_start == 0 && !hi_acc) walking = 1'b0;
            end
            2: ;
            3: begin
                len = word_sr[15:0];
                e = sub_start + 4 * len + 4;
                sub_end = (len == 0 || e > NO_NEXT) ? NO_NEXT : e;
                if (pkt_type == PT_SDES && len >= 2) sdes_ph = SD_CSRC;
            end
            default: begin
                if (pkt_type == PT_SR) begin
                    if (rel[1:0] == 2'd3 && (k <= 6 || (rep_count > 0 && k <= 12)))
                        push_word(k - 1);
                end else if (pkt_type == PT_RR) begin
                    if (rel[1:0] == 2'd3 && (k == 1 || (rep_count > 0 && k <= 7)))
                        push_word(11 + k);
                end else if (pkt_type == PT_SDES) begin
                    case (sdes_ph)
                        SD_CSRC: if (rel == 7) begin
                            push_word(FID_CSRC);
                            sdes_ph = SD_TYPE;
                            item_next = sub_start + 8;
                        end
                        SD_TYPE: if (p == item_next) sdes_ph = (b == 0) ? SD_DONE : SD_LEN;
                        SD_LEN: begin
                            nxt = p + 1 + b;
                            if (nxt >= sub_end) sdes_ph = SD_DONE;
                            else begin
                                if (field_on(FID_TEXT))
                                    push_result(KIND_TEXT, FID_TEXT, '0, p + 1, b, 1'b0, 1'b0);
                                item_next = nxt;
                                sdes_ph = SD_TYPE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endfunction

    function automatic void predict_byte(input t_in_item it);
        int unsigned p;
        p = byte_pos;
        word_sr = {word_sr[23:0], it.data_byte};
        if (p == 0) begin
            ports_good = it.source_port > port_thr && it.destination_port > port_thr;
            if (!ports_good) walking = 1'b0;
        end
        if (walking) walk_byte(p, it.data_byte);
        if (it.last_byte) begin
            push_result(KIND_VERDICT, 0, '0, 0, 8'd0, ports_good && p >= 3 && still_ok, 1'b1);
            restart_packet();
        end else if (p < POS_LIMIT) byte_pos = p + 1;
        else walking = 1'b0;
    endfunction

    initial begin
        err_count = 0;
        hi_acc = 1'b1; fld_mask = '0; port_thr = 16'd1024;
        restart_packet();
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            hi_acc = 1'b1; fld_mask = '0; port_thr = 16'd1024;
            restart_packet();
            expected_results.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HIGH_ACC: hi_acc   = i_cfg_data[0];
                    CFG_FIELD_EN: fld_mask = i_cfg_data;
                    CFG_PORT_THR: port_thr = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // input beat
            if (i_valid && i_in_ready) predict_byte(i_data);
            // result beat
            if (i_out_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result beat, kind",
                                  32'(i_out_data.result_kind), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.result_kind !== want.result_kind)
                        flag_mismatch("result_kind", i_out_data.result_kind, want.result_kind);
                    if (i_out_data.field_id !== want.field_id)
                        flag_mismatch("field_id", i_out_data.field_id, want.field_id);
                    if (i_out_data.field_value !== want.field_value)
                        flag_mismatch("field_value", i_out_data.field_value, want.field_value);
                    if (i_out_data.text_offset !== want.text_offset)
                        flag_mismatch("text_offset", i_out_data.text_offset, want.text_offset);
                    if (i_out_data.text_length !== want.text_length)
                        flag_mismatch("text_length", i_out_data.text_length, want.text_length);
                    if (i_out_data.is_match !== want.is_match)
                        flag_mismatch("is_match", i_out_data.is_match, want.is_match);
                    if (i_out_data.last_result !== want.last_result)
                        flag_mismatch("last_result", i_out_data.last_result, want.last_result);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/rtcp_compound_packet_parser_test.sv]
// Testbench top for the RTCP parser: packet stimulus, flow control and verdict.
module rtcp_compound_packet_parser_test;
    import rtcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [22:0] i_cfg_data;

    int errors, pending;
    int tx_idle, rx_idle, hold_left;
    bit hold_req;
    logic [15:0] cur_thr;
    logic [7:0]  pkt_bytes[$];
    int          bytes_sent;

    rtcp_compound_packet_parser dut (.*);

    rtcp_parse_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready), .i_data(i_data),
        .i_out_valid(o_valid), .i_ready(i_ready), .i_out_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver flow control, with an optional long hold-off
    initial begin
        i_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else i_ready = ($urandom_range(99) >= rx_idle);
        end
    end

    // run limit
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // ready comes from registers only, so its value at the falling edge holds at the next rise
    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic [15:0] sp, input logic [15:0] dp);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data.data_byte = b;
        i_data.last_byte = lst;
        i_data.source_port = sp;
        i_data.destination_port = dp;
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        bytes_sent++;
    endtask

    // sends the assembled packet with ports that mostly clear the threshold
    task automatic send_packet();
        logic [15:0] sp, dp;
        sp = 16'($urandom_range(65535));
        dp = 16'($urandom_range(65535));
        if ($urandom_range(99) < 85 && cur_thr != 16'hFFFF) begin
            sp = 16'($urandom_range(65535, cur_thr + 1));
            dp = 16'($urandom_range(65535, cur_thr + 1));
        end
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, sp, dp);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [22:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic acc, input logic [22:0] mask,
                              input logic [15:0] thr);
        wait_idle();
        write_reg(CFG_HIGH_ACC, {22'd0, acc});
        write_reg(CFG_FIELD_EN, mask);
        write_reg(CFG_PORT_THR, {7'd0, thr});
        cur_thr = thr;
    endtask

    // appends one sub-packet; may break its version or length
    function automatic void add_subpacket(input logic [7:0] pt, input bit first);
        logic [7:0]  body[$];
        logic [4:0]  rc;
        logic [15:0] len;
        logic [7:0]  b0;
        int words, n_items, tl;
        rc = ($urandom_range(99) < 50) ? 5'd0 : 5'($urandom_range(31, 1));
        words = $urandom_range(3);
        if (pt == PT_SR) words = (rc == 0) ? 6 : 12;
        else if (pt == PT_RR) words = (rc == 0) ? 1 : 7;
        if (pt == PT_SDES) begin
            repeat (4) body.push_back(8'($urandom_range(255)));
            n_items = $urandom_range(3);
            repeat (n_items) begin
                tl = ($urandom_range(99) < 4) ? $urandom_range(255, 150) : $urandom_range(12);
                body.push_back(8'($urandom_range(255, 1)));
                body.push_back(8'(tl));
                repeat (tl) body.push_back(8'($urandom_range(255)));
            end
            body.push_back(8'd0);
            while (body.size() % 4 != 0) body.push_back(8'd0);
        end else repeat (4 * words) body.push_back(8'($urandom_range(255)));
        len = 16'(body.size() / 4);
        if ($urandom_range(99) < 8) len = 16'd0;
        else if ($urandom_range(99) < 10) len = $urandom_range(1) ? len + 16'd1 : len - 16'd1;
        else if ($urandom_range(99) < 2) len = 16'($urandom_range(65535));
        b0 = {2'b10, 1'($urandom_range(1)), rc};
        if (first && $urandom_range(99) < 6) b0[7:6] = 2'($urandom_range(3));
        pkt_bytes.push_back(b0);
        pkt_bytes.push_back(pt);
        pkt_bytes.push_back(len[15:8]);
        pkt_bytes.push_back(len[7:0]);
        foreach (body[i]) pkt_bytes.push_back(body[i]);
    endfunction

    function automatic void build_packet();
        int nsub, cut;
        logic [7:0] pt;
        pkt_bytes.delete();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(12, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        nsub = $urandom_range(3, 1);
        for (int s = 0; s < nsub; s++) begin
            pt = 8'($urandom_range(PT_APP, PT_SR));
            if ($urandom_range(99) < 5) pt = 8'($urandom_range(255));
            add_subpacket(pt, s == 0);
        end
        if ($urandom_range(99) < 10) begin
            cut = $urandom_range(pkt_bytes.size() - 1);
            repeat (cut) void'(pkt_bytes.pop_back());
        end
    endfunction

    task automatic run_phase(input int target);
        bytes_sent = 0;
        while (bytes_sent < target) begin
            build_packet();
            send_packet();
        end
    endtask

    task automatic directed(input logic [7:0] b0, input logic [7:0] b1,
                            input int nbytes, input logic [15:0] sp, input logic [15:0] dp);
        logic [7:0] hdr[4];
        hdr = '{b0, b1, 8'd0, 8'd0};
        for (int i = 0; i < nbytes; i++) send_byte(hdr[i], i == nbytes - 1, sp, dp);
    endtask

    initial begin
        int ok_watch;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_HIGH_ACC;
        i_cfg_data = '0;
        hold_req = 1'b0;
        tx_idle = 21;
        rx_idle = 62;
        cur_thr = 16'd1024;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: short packets, bad ports, bad version, type bounds
        set_config(1'b1, 23'h7FFFFF, 16'd1024);
        directed(8'h80, PT_RR, 1, 16'd5000, 16'd5000);
        directed(8'h80, PT_RR, 3, 16'd5000, 16'd5000);
        directed(8'h80, PT_RR, 4, 16'd5000, 16'd5000);
        directed(8'h80, PT_SR, 4, 16'd1024, 16'hFFFF);
        directed(8'h80, PT_SR, 4, 16'hFFFF, 16'd1025);
        directed(8'h40, PT_SDES, 4, 16'd5000, 16'd5000);
        directed(8'hFF, 8'd199, 4, 16'd5000, 16'd5000);
        directed(8'h9F, 8'd205, 4, 16'd5000, 16'd5000);

        // first two phases: sender 21, receiver 62, with one long hold-off
        hold_req = 1'b1;
        run_phase(130);
        set_config(1'b1, 23'd0, 16'd0);
        run_phase(60);

        // next two: sender 62, receiver 21
        tx_idle = 62;
        rx_idle = 21;
        set_config(1'b0, 23'h7FFFFF, 16'hFFFF);
        run_phase(40);
        set_config(1'b1, 23'h600000, 16'd1024);
        run_phase(80);

        // no idling
        tx_idle = 0;
        rx_idle = 0;
        set_config(1'b1, 23'h100000 | 23'($urandom_range(23'h7FFFFF)),
                   16'($urandom_range(2000)));
        run_phase(90);

        @(negedge i_clk);
        i_valid = 1'b0;
        ok_watch = 0;
        while (pending != 0 && ok_watch < 100000) begin
            @(negedge i_clk);
            ok_watch++;
        end
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/rtcp_pkg.sv
sv/rtcp_front.sv
sv/rtcp_back.sv
sv/rtcp_compound_packet_parser.sv
tb/rtcp_parse_checker.sv
tb/rtcp_compound_packet_parser_test.sv
